/* hw/rtl/swm_pkg.sv */
// ----------------------------------------------------------------------------
// swm_pkg
// shared constants for the sliding window minimum filter
// ----------------------------------------------------------------------------
package swm_pkg;

   localparam int MAX_WINDOW_DEFAULT = 64;
   localparam int SAMPLE_W           = 32;
   localparam int WLEN_W             = 7;
   localparam int CSR_ADDR_W         = 3;
   localparam int CSR_DATA_W         = 32;
   localparam int JOB_QUEUE_DEPTH    = 2;

   localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(1);

   // register index, taken from the word address bit
   localparam logic CSR_IDX_WINDOW_LENGTH = 1'b0;

endpackage

/* hw/rtl/swm_ram.sv */
// ----------------------------------------------------------------------------
// swm_ram
// generic one write, one read port ram with registered read data
// ----------------------------------------------------------------------------
module swm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/swm_front.sv */
// ----------------------------------------------------------------------------
// swm_front
// accepts samples, stores them and decides which ones produce a result
// ----------------------------------------------------------------------------
module swm_front
   import swm_pkg::*;
#(
   parameter int MAX_WINDOW = MAX_WINDOW_DEFAULT,
   localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
   localparam int CW = $clog2(MAX_WINDOW + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic                       first,
   output logic                       full,
   input  logic [CW-1:0]              win,
   input  logic                       oldest_vld,
   input  logic [AW-1:0]              oldest_slot,
   input  logic                       queue_full,
   output logic                       ram_wr_en,
   output logic [AW-1:0]              ram_wr_addr,
   output logic [SAMPLE_W-1:0]        ram_wr_data,
   output logic                       job_push,
   output logic [AW-1:0]              job_slot
);

   logic [CW-1:0] fill_ff, fill_in;
   logic [AW-1:0] slot_ff, slot_in;
   logic [CW-1:0] fill_base;
   logic [CW-1:0] ahead;
   logic [CW:0]   thresh;
   logic          hazard;
   logic          accept;

   // distance from the oldest pending window end to the next write slot
   assign ahead  = (slot_ff >= oldest_slot) ? CW'(slot_ff - oldest_slot)
                                            : CW'(MAX_WINDOW) - CW'(oldest_slot) + CW'(slot_ff);
   assign thresh = (CW+1)'(MAX_WINDOW) - {1'b0, win} + (CW+1)'(1);
   assign hazard = oldest_vld &&
                   (ahead == '0 || {1'b0, ahead} >= thresh);

   assign full   = queue_full | hazard;
   assign accept = push & ~full;

   always_comb begin
      fill_base = first ? '0 : fill_ff;
      fill_in   = (fill_base < CW'(MAX_WINDOW)) ? fill_base + CW'(1) : fill_base;
      slot_in   = (slot_ff == AW'(MAX_WINDOW - 1)) ? '0 : slot_ff + AW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         slot_ff <= '0;
      end else if (accept) begin
         fill_ff <= fill_in;
         slot_ff <= slot_in;
      end
   end

   assign ram_wr_en   = accept;
   assign ram_wr_addr = slot_ff;
   assign ram_wr_data = sample;
   assign job_push    = accept && (fill_in >= win);
   assign job_slot    = slot_ff;

endmodule

/* hw/rtl/swm_job_queue.sv */
// ----------------------------------------------------------------------------
// swm_job_queue
// short queue of window end slots between front and back
// ----------------------------------------------------------------------------
module swm_job_queue
   import swm_pkg::*;
#(
   parameter int WIDTH = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head,
   output logic             empty,
   output logic             full
);

   localparam int PW = (JOB_QUEUE_DEPTH > 1) ? $clog2(JOB_QUEUE_DEPTH) : 1;
   localparam int NW = $clog2(JOB_QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [JOB_QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == NW'(JOB_QUEUE_DEPTH));
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(JOB_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(JOB_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hw/rtl/swm_back.sv */
// ----------------------------------------------------------------------------
// swm_back
// walks one window through the sample ram and holds the minimum for output
// ----------------------------------------------------------------------------
module swm_back
   import swm_pkg::*;
#(
   parameter int MAX_WINDOW = MAX_WINDOW_DEFAULT,
   localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
   localparam int CW = $clog2(MAX_WINDOW + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [CW-1:0]               win,
   input  logic                        job_empty,
   input  logic [AW-1:0]               job_slot,
   output logic                        job_pop,
   output logic                        busy,
   output logic [AW-1:0]               cur_slot,
   output logic [AW-1:0]               ram_rd_addr,
   input  logic signed [SAMPLE_W-1:0]  ram_rd_data,
   output logic                        out_empty,
   input  logic                        out_pop,
   output logic signed [SAMPLE_W-1:0]  out_min
);

   logic                       busy_ff, busy_in;
   logic [AW-1:0]              base_ff, base_in;
   logic [AW-1:0]              addr_ff, addr_in;
   logic [CW-1:0]              remain_ff, remain_in;
   logic                       data_vld_ff;
   logic                       data_last_ff;
   logic                       data_first_ff;
   logic                       first_pend_ff, first_pend_in;
   logic signed [SAMPLE_W-1:0] best_ff, best_in;
   logic                       out_vld_ff, out_vld_in;
   logic signed [SAMPLE_W-1:0] out_min_ff, out_min_in;
   logic                       start;
   logic                       issue;
   logic signed [SAMPLE_W-1:0] cand;

   assign start = ~busy_ff & ~job_empty & ~out_vld_ff;
   assign issue = busy_ff & (remain_ff != '0);
   assign cand  = (data_first_ff || ram_rd_data < best_ff) ? ram_rd_data : best_ff;

   always_comb begin
      busy_in       = busy_ff;
      base_in       = base_ff;
      addr_in       = addr_ff;
      remain_in     = remain_ff;
      first_pend_in = first_pend_ff;
      best_in       = best_ff;
      out_vld_in    = out_vld_ff;
      out_min_in    = out_min_ff;
      if (start) begin
         busy_in       = 1'b1;
         base_in       = job_slot;
         addr_in       = job_slot;
         remain_in     = win;
         first_pend_in = 1'b1;
      end
      if (issue) begin
         addr_in       = (addr_ff == '0) ? AW'(MAX_WINDOW - 1) : addr_ff - AW'(1);
         remain_in     = remain_ff - CW'(1);
         first_pend_in = 1'b0;
      end
      if (data_vld_ff) begin
         best_in = cand;
      end
      if (data_vld_ff && data_last_ff) begin
         busy_in    = 1'b0;
         out_vld_in = 1'b1;
         out_min_in = cand;
      end else if (out_pop && out_vld_ff) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         remain_ff     <= '0;
         data_vld_ff   <= 1'b0;
         data_last_ff  <= 1'b0;
         data_first_ff <= 1'b0;
         first_pend_ff <= 1'b0;
         out_vld_ff    <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         remain_ff     <= remain_in;
         data_vld_ff   <= issue;
         data_last_ff  <= issue && (remain_ff == CW'(1));
         data_first_ff <= issue && first_pend_ff;
         first_pend_ff <= first_pend_in;
         out_vld_ff    <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff    <= base_in;
      addr_ff    <= addr_in;
      best_ff    <= best_in;
      out_min_ff <= out_min_in;
   end

   assign job_pop     = start;
   assign busy        = busy_ff;
   assign cur_slot    = base_ff;
   assign ram_rd_addr = addr_ff;
   assign out_empty   = ~out_vld_ff;
   assign out_min     = out_min_ff;

endmodule

/* hw/rtl/sliding_window_minimum.sv */
// ----------------------------------------------------------------------------
// sliding_window_minimum
// minimum of the most recent window_length signed samples of a stream
// ----------------------------------------------------------------------------
// input queue side: req_sample and req_first are taken when req_push is high
// and req_full is low. req_first restarts the sequence with that item.
// result queue side: rsp_window_min is valid while rsp_empty is low and is
// taken when rsp_pop is high.
// register window_length (byte address 0) sets the window, 0 acts as 1,
// values above MAX_WINDOW act as MAX_WINDOW. reset value 1.
// an item that produces no result is only stored in the sample ram.
// an item that produces a result occupies the back for the start step,
// one read of the sample ram per entry of the effective window, the
// registered ram read and the time the result waits in the output
// register until it is popped.
// the front keeps taking items while a result waits, until the job queue
// (two entries) fills or a new sample would overwrite a pending window.
// reset empties both queues and restarts the fill count; the sample ram is
// not cleared.
// ----------------------------------------------------------------------------
module sliding_window_minimum
   import swm_pkg::*;
#(
   parameter int MAX_WINDOW = MAX_WINDOW_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic signed [SAMPLE_W-1:0]  req_sample,
   input  logic                        req_first,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic signed [SAMPLE_W-1:0]  rsp_window_min,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [CSR_ADDR_W-1:0]       paddr,
   input  logic [CSR_DATA_W-1:0]       pwdata,
   output logic [CSR_DATA_W-1:0]       prdata,
   output logic                        pready
);

   localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CW = $clog2(MAX_WINDOW + 1);

   logic [WLEN_W-1:0]   wlen_ff, wlen_in;
   logic [CW-1:0]       win;
   logic                csr_wr;
   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [SAMPLE_W-1:0] ram_wr_data;
   logic [AW-1:0]       ram_rd_addr;
   logic [SAMPLE_W-1:0] ram_rd_data;
   logic                job_push;
   logic [AW-1:0]       job_slot;
   logic                job_pop;
   logic [AW-1:0]       job_head;
   logic                job_empty;
   logic                job_full;
   logic                back_busy;
   logic [AW-1:0]       back_slot;
   logic                oldest_vld;
   logic [AW-1:0]       oldest_slot;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready;

   always_comb begin
      wlen_in = wlen_ff;
      if (csr_wr && paddr[2] == CSR_IDX_WINDOW_LENGTH) begin
         wlen_in = pwdata[WLEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff <= WLEN_RESET;
      end else begin
         wlen_ff <= wlen_in;
      end
   end

   assign prdata = (paddr[2] == CSR_IDX_WINDOW_LENGTH) ?
                   {{(CSR_DATA_W-WLEN_W){1'b0}}, wlen_ff} : '0;

   always_comb begin
      if (wlen_ff == '0) begin
         win = CW'(1);
      end else if ({{(32-WLEN_W){1'b0}}, wlen_ff} > 32'(MAX_WINDOW)) begin
         win = CW'(MAX_WINDOW);
      end else begin
         win = CW'(wlen_ff);
      end
   end

   assign oldest_vld  = back_busy | ~job_empty;
   assign oldest_slot = back_busy ? back_slot : job_head;

   swm_front #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (req_push),
      .sample      (req_sample),
      .first       (req_first),
      .full        (req_full),
      .win         (win),
      .oldest_vld  (oldest_vld),
      .oldest_slot (oldest_slot),
      .queue_full  (job_full),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .job_push    (job_push),
      .job_slot    (job_slot)
   );

   swm_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_WINDOW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   swm_job_queue #(
      .WIDTH (AW)
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_slot),
      .pop       (job_pop),
      .head      (job_head),
      .empty     (job_empty),
      .full      (job_full)
   );

   swm_back #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .win         (win),
      .job_empty   (job_empty),
      .job_slot    (job_head),
      .job_pop     (job_pop),
      .busy        (back_busy),
      .cur_slot    (back_slot),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .out_empty   (rsp_empty),
      .out_pop     (rsp_pop),
      .out_min     (rsp_window_min)
   );

endmodule
